/* sv/rgbc_pkg.sv */
`default_nettype none
package rgbc_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int KERNEL_SIZE = 5;
  localparam int HALF        = KERNEL_SIZE / 2;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int BANK_W      = $clog2(LINES);
  localparam int TAP_W       = $clog2(TAPS);
  localparam int ROW_W       = 13;
  localparam int SIZE_W      = 12;
  localparam int CFG_DATA_W  = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int ACC_W       = 21;
  localparam int SCALE_W     = 24;
  localparam int BIAS_W      = 17;
  localparam int PROD_W      = ACC_W + SCALE_W;
  localparam int TOTAL_W     = PROD_W + 1;
  localparam int COEF_ALL_W  = TAPS * 8;

  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic             load;
    logic             update;
    logic             mac_clr;
    logic             mac_en;
    logic [TAP_W-1:0] tap;
    logic             scale_en;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic result;
    logic border;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* sv/rgbc_in_if.sv */
`default_nettype none
interface rgbc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, op, red, green, blue, input ready);
  modport sink (input valid, op, red, green, blue, output ready);
endinterface
`default_nettype wire

/* sv/rgbc_out_if.sv */
`default_nettype none
interface rgbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

/* sv/rgbc_ctrl.sv */
`default_nettype none
module rgbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rgbc_pkg::sts_t sts,
  output rgbc_pkg::cmd_t cmd
);
  import rgbc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_UPDATE, S_MAC, S_SCALE, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tap   = tap_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !sts.drop) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update  = 1'b1;
        cmd.mac_clr = 1'b1;
        tap_nxt     = '0;
        if (!sts.result) state_nxt = S_IDLE;
        else if (sts.border) state_nxt = S_EMIT;
        else state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        tap_nxt    = tap_r + 1'b1;
        if (tap_r == TAP_W'(TAPS - 1)) state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/rgbc_dp.sv */
`default_nettype none
module rgbc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rgbc_pkg::cmd_t                       cmd,
  output rgbc_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_op,
  input  logic [7:0]                           in_red,
  input  logic [7:0]                           in_green,
  input  logic [7:0]                           in_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic                                 frame_end
);
  import rgbc_pkg::*;

  // Configuration registers.
  logic [55:0]                coef0_r, coef1_r, coef2_r;
  logic [31:0]                coef3_r;
  logic signed [SCALE_W-1:0]  scale_r;
  logic signed [BIAS_W-1:0]   bias_r;
  logic [SIZE_W-1:0]          width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef0_r  <= '0;
      coef1_r  <= 56'd1099511627776;
      coef2_r  <= '0;
      coef3_r  <= '0;
      scale_r  <= SCALE_W'(65536);
      bias_r   <= '0;
      width_r  <= SIZE_W'(512);
      height_r <= SIZE_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF0:  coef0_r  <= cfg_data;
        REG_COEF1:  coef1_r  <= cfg_data;
        REG_COEF2:  coef2_r  <= cfg_data;
        REG_COEF3:  coef3_r  <= cfg_data[31:0];
        REG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
        REG_BIAS:   bias_r   <= cfg_data[BIAS_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COEF_ALL_W-1:0] coef_all;
  assign coef_all = {coef3_r, coef2_r, coef1_r, coef0_r};

  // Sizes saturated to the supported range.
  logic [SIZE_W-1:0] w, h;
  always_comb begin
    if (width_r < SIZE_W'(KERNEL_SIZE)) w = SIZE_W'(KERNEL_SIZE);
    else if (width_r > SIZE_W'(MAX_WIDTH)) w = SIZE_W'(MAX_WIDTH);
    else w = width_r;
    if (height_r < SIZE_W'(KERNEL_SIZE)) h = SIZE_W'(KERNEL_SIZE);
    else if (height_r > SIZE_W'(MAX_HEIGHT)) h = SIZE_W'(MAX_HEIGHT);
    else h = height_r;
  end

  logic [COL_W-1:0] in_column_r, out_column_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic             flush;
  assign flush = in_row_r >= ROW_W'(h);
  assign sts.drop = in_op && !flush;

  // Line store: one bank per buffered row.
  pixel_t mem [LINES][MAX_WIDTH];
  pixel_t rd_r [LINES];
  pixel_t pix_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= {in_red, in_green, in_blue};
      for (int b = 0; b < LINES; b++) rd_r[b] <= mem[b][in_column_r];
    end
    if (cmd.update && !flush) mem[in_row_r[BANK_W-1:0]][in_column_r] <= pix_r;
  end

  // Position and border decisions.
  logic [SIZE_W+ROW_W-1:0] pos, thresh;
  logic [SIZE_W-1:0]       col_inc, ocol_inc;
  logic                    has_res, border, last;
  always_comb begin
    pos    = (SIZE_W+ROW_W)'(in_row_r) * (SIZE_W+ROW_W)'(w)
           + (SIZE_W+ROW_W)'(in_column_r);
    thresh = ((SIZE_W+ROW_W)'(w) << 1) + (SIZE_W+ROW_W)'(HALF);
    has_res = pos >= thresh;
    col_inc  = SIZE_W'(in_column_r) + 1'b1;
    ocol_inc = SIZE_W'(out_column_r) + 1'b1;
    border = (SIZE_W'(out_column_r) < SIZE_W'(HALF))
          || (SIZE_W'(out_column_r) >= w - SIZE_W'(HALF))
          || (out_row_r < ROW_W'(HALF))
          || (out_row_r >= ROW_W'(h) - ROW_W'(HALF));
    last = (out_row_r > ROW_W'(h) - 1'b1)
        || ((out_row_r == ROW_W'(h) - 1'b1) && (SIZE_W'(out_column_r) >= w - 1'b1));
  end
  assign sts.result = has_res;
  assign sts.border = border;

  logic border_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
    end else if (cmd.update) begin
      if (has_res && last) begin
        in_column_r  <= '0;
        in_row_r     <= '0;
        out_column_r <= '0;
        out_row_r    <= '0;
      end else begin
        if (col_inc >= w) begin
          in_column_r <= '0;
          in_row_r    <= in_row_r + 1'b1;
        end else begin
          in_column_r <= col_inc[COL_W-1:0];
        end
        if (has_res) begin
          if (ocol_inc >= w) begin
            out_column_r <= '0;
            out_row_r    <= out_row_r + 1'b1;
          end else begin
            out_column_r <= ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      border_r <= border;
      last_r   <= last;
    end
  end

  // 5x5 window, row-major, newest column at the right.
  pixel_t win_r [TAPS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAPS; t++) win_r[t] <= '0;
    end else if (cmd.update && !flush) begin
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++)
          win_r[l*KERNEL_SIZE+k] <= win_r[l*KERNEL_SIZE+k+1];
        if (l < LINES)
          win_r[l*KERNEL_SIZE+KERNEL_SIZE-1] <= rd_r[BANK_W'(in_row_r[BANK_W-1:0] + BANK_W'(l))];
        else
          win_r[l*KERNEL_SIZE+KERNEL_SIZE-1] <= pix_r;
      end
    end
  end

  // One tap per cycle for all three channels.
  logic signed [7:0]       coef;
  pixel_t                  wpix;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [16:0]      mul [3];

  assign coef = coef_all[cmd.tap*8 +: 8];
  assign wpix = win_r[cmd.tap];

  always_comb begin
    for (int c = 0; c < 3; c++)
      mul[c] = coef * $signed({1'b0, wpix[(2-c)*8 +: 8]});
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.mac_clr) acc_r[c] <= '0;
      else if (cmd.mac_en) acc_r[c] <= acc_r[c] + ACC_W'(mul[c]);
      if (cmd.scale_en) prod_r[c] <= PROD_W'(acc_r[c]) * PROD_W'(scale_r);
    end
  end

  logic signed [TOTAL_W-1:0] total [3];
  logic [7:0]                clamped [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total[c] = TOTAL_W'(prod_r[c]) + (TOTAL_W'(bias_r) <<< 8);
      if (total[c] < 0) clamped[c] = 8'd0;
      else if (total[c][TOTAL_W-1:16] > (TOTAL_W-16)'(255)) clamped[c] = 8'd255;
      else clamped[c] = total[c][23:16];
    end
  end

  logic valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (cmd.emit) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_red   <= border_r ? 8'd0 : clamped[0];
      out_green <= border_r ? 8'd0 : clamped[1];
      out_blue  <= border_r ? 8'd0 : clamped[2];
      frame_end <= last_r;
    end
  end

  assign out_valid    = valid_r;
  assign sts.out_busy = valid_r && !out_ready;

endmodule
`default_nettype wire

/* sv/rgb_convolution_5x5_clamped_unit.sv */
`default_nettype none
// Streaming 5x5 RGB convolution. Pixels enter in raster order on in_ch; each
// color channel is filtered with a signed 5x5 kernel, scaled by a signed Q8.16
// reciprocal, offset by a bias in 1/256 pixel units, clamped to 0..255 and
// sent on out_ch. Output pixels within two of a frame edge are zero, and
// results lag the input by two rows plus two pixels, so after the last pixel
// of a frame the source sends drain items until the item with frame_end
// comes out. The user must write registers through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this. The
// block works on one item at a time. A drain item that arrives before the
// last pixel of the frame is taken and ignored. Any other item that yields
// no result is stored and ends there, a border result is then emitted, and
// an interior result is computed by the single multiply-accumulate unit per
// channel that walks the 25 kernel taps one per cycle, followed by a scaling
// multiply. A finished item waits in the output register while the next item
// is taken. The line store is four banks of 2048 pixels, one per buffered row.
module rgb_convolution_5x5_clamped_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  rgbc_in_if.sink                           in_ch,
  rgbc_out_if.source                        out_ch
);
  import rgbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item; the datapath owns storage and math.
  rgbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (in_ch.op),
    .in_red    (in_ch.red),
    .in_green  (in_ch.green),
    .in_blue   (in_ch.blue),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.out_red),
    .out_green (out_ch.out_green),
    .out_blue  (out_ch.out_blue),
    .frame_end (out_ch.frame_end)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
  import rgbc_pkg::*;

  // One expected output pixel.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } out_pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rgbc_in_if  in_ch ();
  rgbc_out_if out_ch ();

  rgb_convolution_5x5_clamped_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // The clock has a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the registers and of the filter state. The line store is
  // modeled as zero; only border outputs may ever see an unwritten entry.
  logic [CFG_DATA_W-1:0] reg_shadow [8];
  bit   [23:0]           line_mem [LINES*MAX_WIDTH];
  bit   [23:0]           win [TAPS];
  int unsigned           in_col, in_row, out_col, out_row;
  bit                    frame_done;

  out_pixel_t            pending_pixels[$];
  int                    mismatches;
  int                    items_sent;
  bit                    no_idle;
  int                    stall_request;
  int                    stall_left;
  int                    ready_gap;

  function automatic int unsigned active_width();
    int unsigned w;
    w = reg_shadow[REG_WIDTH][SIZE_W-1:0];
    if (w < 5) w = 5;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = reg_shadow[REG_HEIGHT][SIZE_W-1:0];
    if (h < 5) h = 5;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Filters one color channel of the current window; sh selects the channel.
  function automatic logic [7:0] filter_channel(int sh);
    longint     acc;
    longint     total;
    logic [7:0] coef;
    acc = 0;
    for (int t = 0; t < TAPS; t++) begin
      coef = reg_shadow[t / 7][8 * (t % 7) +: 8];
      acc += longint'($signed(coef)) * longint'(win[t][sh +: 8]);
    end
    total = acc * longint'($signed(reg_shadow[REG_SCALE][SCALE_W-1:0]))
          + longint'($signed(reg_shadow[REG_BIAS][BIAS_W-1:0])) * 256;
    if (total < 0) return 8'd0;
    total = total >>> 16;
    return (total > 255) ? 8'd255 : total[7:0];
  endfunction

  // Advances the filter state by one accepted item and queues its output.
  function automatic void advance_filter(logic drain, bit [23:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    longint      pos;
    bit          flushing;
    bit          last;
    out_pixel_t  px;
    w = active_width();
    h = active_height();
    flushing = in_row >= h;
    if (drain && !flushing) return;
    if (!flushing) begin
      c = in_col % MAX_WIDTH;
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++)
          win[l*KERNEL_SIZE + k] = win[l*KERNEL_SIZE + k + 1];
        win[l*KERNEL_SIZE + KERNEL_SIZE - 1] = (l < KERNEL_SIZE - 1) ?
            line_mem[((in_row + l) % LINES) * MAX_WIDTH + c] : pix;
      end
      line_mem[(in_row % LINES) * MAX_WIDTH + c] = pix;
    end
    pos = longint'(in_row) * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < 2 * longint'(w) + 2) return;
    if (out_col < HALF || out_col >= w - HALF || out_row < HALF || out_row >= h - HALF) begin
      px.red = 0;
      px.green = 0;
      px.blue = 0;
    end else begin
      px.red = filter_channel(16);
      px.green = filter_channel(8);
      px.blue = filter_channel(0);
    end
    last = out_row > h - 1 || (out_row == h - 1 && out_col >= w - 1);
    px.frame_end = last;
    pending_pixels.push_back(px);
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_done = 1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Most gaps are short, a few are long, and none while no_idle is set.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item and waits for it to be taken. Ready is looked at on the
  // falling edge, where nothing changes, so the acceptance is race free.
  task automatic send_item(logic drain, bit [23:0] pix);
    logic taken;
    int   gap;
    in_ch.valid <= 1'b1;
    in_ch.op    <= drain;
    in_ch.red   <= pix[23:16];
    in_ch.green <= pix[15:8];
    in_ch.blue  <= pix[7:0];
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    advance_filter(drain, pix);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] mask;
    case (idx) inside
      REG_COEF3:  mask = {24'd0, {32{1'b1}}};
      REG_SCALE:  mask = {32'd0, {SCALE_W{1'b1}}};
      REG_BIAS:   mask = {39'd0, {BIAS_W{1'b1}}};
      REG_WIDTH,
      REG_HEIGHT: mask = {44'd0, {SIZE_W{1'b1}}};
      default:    mask = {CFG_DATA_W{1'b1}};
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_shadow[idx] = value & mask;
  endtask

  // Stops offering items and waits until every expected pixel has come out,
  // then lets the block finish any item that produced nothing.
  task automatic drain_out();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic bit [23:0] random_pixel(bit extremes);
    if (extremes) begin
      case ($urandom_range(3))
        0: return 24'h000000;
        1: return 24'hFFFFFF;
        2: return {$urandom_range(1) ? 8'hFF : 8'h00, 8'h00, 8'hFF};
        default: return 24'($urandom);
      endcase
    end
    return 24'($urandom);
  endfunction

  // Feeds pixels and then drain items until the frame-end pixel is expected.
  // With noise on, stray drains land in the input phase and stray pixels in
  // the flush phase.
  task automatic run_frame(bit extremes, bit noise);
    frame_done = 0;
    while (!frame_done) begin
      if (in_row >= active_height())
        send_item(!(noise && $urandom_range(9) == 0), random_pixel(extremes));
      else if (noise && $urandom_range(19) == 0)
        send_item(1'b1, random_pixel(extremes));
      else
        send_item(1'b0, random_pixel(extremes));
    end
  endtask

  task automatic set_kernel(logic [55:0] g0, logic [55:0] g1, logic [55:0] g2,
                            logic [31:0] g3, int scale, int bias);
    write_reg(REG_COEF0, g0);
    write_reg(REG_COEF1, g1);
    write_reg(REG_COEF2, g2);
    write_reg(REG_COEF3, {24'd0, g3});
    write_reg(REG_SCALE, CFG_DATA_W'(scale[SCALE_W-1:0]));
    write_reg(REG_BIAS, CFG_DATA_W'(bias[BIAS_W-1:0]));
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  // Reset kernel (center tap only, unity scale) on a small frame.
  task automatic test_reset_kernel();
    set_size(8, 6);
    run_frame(1, 0);
    drain_out();
  endtask

  // Extreme coefficients, scale and bias on minimum-size frames.
  task automatic test_extreme_kernels();
    set_size(5, 5);
    set_kernel({7{8'h7F}}, {7{8'h7F}}, {7{8'h7F}}, {4{8'h7F}}, 8388607, 65535);
    run_frame(1, 0);
    drain_out();
    set_kernel({7{8'h80}}, {7{8'h80}}, {7{8'h80}}, {4{8'h80}}, -8388608, -65536);
    run_frame(1, 0);
    drain_out();
    set_kernel({7{8'h80}}, {7{8'h80}}, {7{8'h80}}, {4{8'h80}}, 8388607, 0);
    run_frame(1, 0);
    drain_out();
  endtask

  // Sizes below 5 saturate up to the minimum frame. A width above 2048
  // saturates to 2048: a few pixels go in on such a row, then the width drops
  // to 6 while the counters keep running.
  task automatic test_size_limits();
    set_kernel(56'({$urandom, $urandom}), 56'({$urandom, $urandom}),
               56'({$urandom, $urandom}), $urandom, 2600, 512);
    set_size(0, 3);
    run_frame(0, 0);
    drain_out();
    set_size(4095, 5);
    for (int i = 0; i < 7; i++) send_item(1'b0, random_pixel(0));
    drain_out();
    write_reg(REG_WIDTH, CFG_DATA_W'(6));
    run_frame(0, 0);
    drain_out();
    set_size(2048, 2048);
    set_size(5, 5);
    run_frame(0, 1);
    drain_out();
  endtask

  // Shrinks the height while a frame is in flight, once to a row ahead of
  // the output and once to a row the output has already passed.
  task automatic test_height_shrink();
    set_size(6, 10);
    for (int i = 0; i < 6 * 3; i++) send_item(1'b0, random_pixel(0));
    drain_out();
    write_reg(REG_HEIGHT, CFG_DATA_W'(5));
    run_frame(0, 0);
    drain_out();
    set_size(6, 10);
    for (int i = 0; i < 6 * 8; i++) send_item(1'b0, random_pixel(0));
    drain_out();
    write_reg(REG_HEIGHT, CFG_DATA_W'(5));
    run_frame(0, 0);
    drain_out();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block has to stall its input.
  task automatic test_output_stall();
    set_size(7, 6);
    no_idle = 1;
    stall_request = 500;
    run_frame(0, 0);
    no_idle = 0;
    drain_out();
  endtask

  // Random kernels and small frames until about 1350 items have gone in
  // over the whole run.
  task automatic test_random_frames();
    int scale;
    int target;
    target = 1350;
    while (items_sent < target) begin
      case ($urandom_range(3))
        0: scale = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        1: scale = $urandom_range(1, 8191);
        2: scale = 65536;
        default: scale = -$urandom_range(1, 8191);
      endcase
      set_kernel(56'({$urandom, $urandom}), 56'({$urandom, $urandom}),
                 56'({$urandom, $urandom}), $urandom, scale, $urandom);
      set_size($urandom_range(5, 12), $urandom_range(5, 8));
      run_frame($urandom_range(3) == 0, $urandom_range(4) == 0);
      if ($urandom_range(2) == 0) drain_out();
      else begin
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
      end
    end
    drain_out();
  endtask

  // Receiver readiness: random short and long gaps, plus a long hold-off
  // when a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      ready_gap = 0;
    end else if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      ready_gap = pick_gap();
      out_ch.ready <= (ready_gap == 0);
    end
  end

  // Compares each output pixel, at the falling edge before it is taken,
  // with the oldest expected one.
  always @(negedge clk) begin : check_pixels
    out_pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output pixel %h %h %h end=%b", out_ch.out_red,
                   out_ch.out_green, out_ch.out_blue, out_ch.frame_end);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.out_red !== want.red || out_ch.out_green !== want.green ||
            out_ch.out_blue !== want.blue || out_ch.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel mismatch: expected %h %h %h end=%b, got %h %h %h end=%b",
                     want.red, want.green, want.blue, want.frame_end,
                     out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                     out_ch.frame_end);
        end
      end
    end
  end

  // Main sequence: reset, then each test in turn.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    no_idle = 0;
    stall_request = 0;
    reg_shadow[REG_COEF0]  = '0;
    reg_shadow[REG_COEF1]  = 56'd1099511627776;
    reg_shadow[REG_COEF2]  = '0;
    reg_shadow[REG_COEF3]  = '0;
    reg_shadow[REG_SCALE]  = 56'd65536;
    reg_shadow[REG_BIAS]   = '0;
    reg_shadow[REG_WIDTH]  = 56'd512;
    reg_shadow[REG_HEIGHT] = 56'd512;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_kernel();
    test_extreme_kernels();
    test_size_limits();
    test_height_shrink();
    test_output_stall();
    test_random_frames();

    // Leftover expectations fail here too.
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* rgb_convolution_5x5_clamped_unit.f */
sv/rgbc_pkg.sv
sv/rgbc_in_if.sv
sv/rgbc_out_if.sv
sv/rgbc_ctrl.sv
sv/rgbc_dp.sv
sv/rgb_convolution_5x5_clamped_unit.sv
tb/tb_top.sv
